/* sv/clzss_pkg.sv */
// ----------------------------------------------------------------------------
// clzss_pkg
// Shared types and constants for the configurable lzss decoder.
// ----------------------------------------------------------------------------
package clzss_pkg;

  // width of the raw offset field carried by a reference
  localparam int OFF_W = 12;
  // width of the encoded length field
  localparam int LEN_W = 4;
  // copy length: length field plus threshold, at most 18
  localparam int RUN_W = 5;
  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_FLAGS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_MSB_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PACK_FORMAT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_BYTE      = 3'd5;

  localparam logic [1:0] PACK_LO_HI12  = 2'd0;
  localparam logic [1:0] PACK_HI_LO4   = 2'd1;
  localparam logic [1:0] PACK_LO_HIHI  = 2'd2;
  localparam logic [1:0] PACK_LO4_HI4  = 2'd3;

  // reset values of the registers
  localparam logic [1:0]  THRESHOLD_RST      = 2'd2;
  localparam logic [10:0] START_POSITION_RST = 11'd2030;
  localparam logic [7:0]  FILL_BYTE_RST      = 8'd32;

  // flag bit index that means a new flag byte is expected
  localparam logic [3:0] FLAG_IDX_DONE = 4'd8;

  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_ITEM = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

endpackage

/* sv/configurable_lzss_decoder.sv */
// ----------------------------------------------------------------------------
// configurable_lzss_decoder
// LZSS decompressor with a ring history window and configurable packing.
// ----------------------------------------------------------------------------
// One compressed byte enters per item on in_valid/in_ready, with end_of_stream
// marking the last byte of a stream. Decompressed bytes leave on
// out_valid/out_ready; last_of_run marks the final byte caused by one input.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data).
//
// Timing: a flag byte, a reference low byte, a literal or a zero-length
// reference passes S_IDLE and S_PROC; a literal goes from byte_q to the
// output register in S_PROC. A reference high byte with a copy of L bytes
// passes S_IDLE, S_PROC, S_OFFRED (R passes of the shared subtract unit that
// fold the offset into the window, R 0 or 1 at a 2048 byte window) and S_CP,
// one byte a cycle through the window read port while the receiver takes them.
// A stream's first byte also passes S_WPRED (P passes fold start_position,
// 0 at a 2048 byte window). The block takes no new item while one is in work.
//
// Reset clears the parser and sets the registers to their reset values. The
// window is never swept: a count of bytes written since stream start tells
// which entries still hold the fill byte. A stalled receiver holds the output
// register and stops the copy in place; nothing is lost.
// ----------------------------------------------------------------------------
module configurable_lzss_decoder #(
  parameter int WINDOW_SIZE = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [clzss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clzss_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_byte,
  input  logic                              end_of_stream,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              last_of_run
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam int CW = AW + 1;
  localparam logic [clzss_pkg::OFF_W:0] WSZ    = (clzss_pkg::OFF_W + 1)'(WINDOW_SIZE);
  localparam logic [AW-1:0]             WLAST  = AW'(WINDOW_SIZE - 1);
  localparam logic [CW-1:0]             CFULL  = CW'(WINDOW_SIZE);
  localparam logic [CW-1:0]             WSZ_CW = CW'(WINDOW_SIZE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WPRED,
    S_PROC,
    S_OFFRED,
    S_CP
  } state_t;

  // configuration registers
  logic [1:0]  threshold;
  logic [10:0] start_position;
  logic        invert_flags;
  logic        flag_msb_first;
  logic [1:0]  pack_format;
  logic [7:0]  fill_byte;

  state_t                          state;
  clzss_pkg::phase_t               phase;
  logic [7:0]                      flags;
  logic [3:0]                      flag_idx;
  logic [7:0]                      saved_low;
  logic                            stream_open;
  logic [7:0]                      byte_q;
  logic                            eos_q;
  logic [7:0]                      fill_lat;
  logic [AW-1:0]                   wp;
  logic [AW-1:0]                   base;
  logic [CW-1:0]                   count;
  logic [clzss_pkg::OFF_W-1:0]     acc;
  logic [AW-1:0]                   caddr;
  logic [clzss_pkg::RUN_W-1:0]     remaining;

  // window memory and its read side
  logic [7:0]    window [WINDOW_SIZE];
  logic [7:0]    mem_q;
  logic          fwd_q;
  logic [7:0]    fwd_d;
  logic          inwin_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [CW-1:0] ra_dist;

  logic                         can_emit;
  logic                         flag_bit;
  logic                         lit_emit;
  logic                         cp_emit;
  logic [7:0]                   cp_data;
  logic                         red_done;
  logic                         sub_ge;
  logic [clzss_pkg::OFF_W-1:0]  sub_out;
  logic [AW-1:0]                wp_inc;
  logic [AW-1:0]                caddr_inc;
  logic [CW-1:0]                count_inc;
  logic [clzss_pkg::OFF_W-1:0]  ref_off;
  logic [clzss_pkg::LEN_W-1:0]  ref_len;
  logic [clzss_pkg::RUN_W-1:0]  run_len;
  logic                         finish;
  logic [3:0]                   idx_next;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    ring_inc = (a == WLAST) ? '0 : a + 1'b1;
  endfunction

  // shared subtract unit: folds offsets and the start position into the window
  assign sub_ge  = {1'b0, acc} >= WSZ;
  assign sub_out = clzss_pkg::OFF_W'({1'b0, acc} - WSZ);

  assign in_ready  = (state == S_IDLE);
  assign can_emit  = !out_valid || out_ready;
  assign wp_inc    = ring_inc(wp);
  assign caddr_inc = ring_inc(caddr);
  assign count_inc = (count == CFULL) ? count : count + 1'b1;
  assign idx_next  = flag_idx + 1'b1;

  always_comb begin
    flag_bit = flag_msb_first ? flags[3'd7 - flag_idx[2:0]] : flags[flag_idx[2:0]];
    lit_emit = (state == S_PROC) && (phase == clzss_pkg::PH_ITEM) && flag_bit && can_emit;
    cp_emit  = (state == S_CP) && can_emit;
    red_done = (state == S_OFFRED) && !sub_ge;
    // entries not written since stream start still hold the fill byte
    if (fwd_q) begin
      cp_data = fwd_d;
    end else if (inwin_q) begin
      cp_data = mem_q;
    end else begin
      cp_data = fill_lat;
    end
    mem_we = lit_emit || cp_emit;
    mem_wa = wp;
    mem_wd = lit_emit ? byte_q : cp_data;
    mem_re = red_done || (cp_emit && remaining != 5'd1);
    mem_ra = red_done ? acc[AW-1:0] : caddr_inc;
    if (mem_ra >= base) begin
      ra_dist = {1'b0, mem_ra} - {1'b0, base};
    end else begin
      ra_dist = {1'b0, mem_ra} + WSZ_CW - {1'b0, base};
    end
  end

  always_comb begin
    case (pack_format)
      clzss_pkg::PACK_LO_HI12: begin
        ref_off = {byte_q[3:0], saved_low};
        ref_len = byte_q[7:4];
      end
      clzss_pkg::PACK_HI_LO4: begin
        ref_off = {byte_q, saved_low[7:4]};
        ref_len = saved_low[3:0];
      end
      clzss_pkg::PACK_LO_HIHI: begin
        ref_off = {byte_q[7:4], saved_low};
        ref_len = byte_q[3:0];
      end
      default: begin
        ref_off = {saved_low, byte_q[7:4]};
        ref_len = byte_q[3:0];
      end
    endcase
    run_len = {1'b0, ref_len} + {3'b000, threshold};
  end

  always_comb begin
    finish = 1'b0;
    if (state == S_PROC) begin
      unique case (phase)
        clzss_pkg::PH_ITEM: finish = !flag_bit || can_emit;
        clzss_pkg::PH_HIGH: finish = (run_len == '0);
        default:            finish = 1'b1;
      endcase
    end else if (cp_emit && remaining == 5'd1) begin
      finish = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      window[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= window[mem_ra];
      // a read of the entry written in the same cycle takes the new byte
      fwd_q   <= mem_we && (mem_ra == mem_wa);
      fwd_d   <= mem_wd;
      inwin_q <= ra_dist < count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= clzss_pkg::THRESHOLD_RST;
      start_position <= clzss_pkg::START_POSITION_RST;
      invert_flags   <= 1'b0;
      flag_msb_first <= 1'b0;
      pack_format    <= clzss_pkg::PACK_LO_HI12;
      fill_byte      <= clzss_pkg::FILL_BYTE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        clzss_pkg::REG_THRESHOLD:      threshold      <= cfg_data[1:0];
        clzss_pkg::REG_START_POSITION: start_position <= cfg_data[10:0];
        clzss_pkg::REG_INVERT_FLAGS:   invert_flags   <= cfg_data[0];
        clzss_pkg::REG_FLAG_MSB_FIRST: flag_msb_first <= cfg_data[0];
        clzss_pkg::REG_PACK_FORMAT:    pack_format    <= cfg_data[1:0];
        clzss_pkg::REG_FILL_BYTE:      fill_byte      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= clzss_pkg::PH_FLAG;
      flags       <= '0;
      flag_idx    <= clzss_pkg::FLAG_IDX_DONE;
      saved_low   <= '0;
      stream_open <= 1'b0;
      out_valid   <= 1'b0;
      count       <= '0;
      remaining   <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            byte_q <= in_byte;
            eos_q  <= end_of_stream;
            if (!stream_open) begin
              stream_open <= 1'b1;
              fill_lat    <= fill_byte;
              acc         <= {1'b0, start_position};
              count       <= '0;
              state       <= S_WPRED;
            end else begin
              state <= S_PROC;
            end
          end
        end
        S_WPRED: begin
          if (sub_ge) begin
            acc <= sub_out;
          end else begin
            wp    <= acc[AW-1:0];
            base  <= acc[AW-1:0];
            state <= S_PROC;
          end
        end
        S_PROC: begin
          unique case (phase)
            clzss_pkg::PH_ITEM: begin
              if (!flag_bit) begin
                saved_low <= byte_q;
                phase     <= clzss_pkg::PH_HIGH;
              end else if (can_emit) begin
                out_valid   <= 1'b1;
                out_byte    <= byte_q;
                last_of_run <= 1'b1;
                wp          <= wp_inc;
                count       <= count_inc;
                if (idx_next >= clzss_pkg::FLAG_IDX_DONE) begin
                  flag_idx <= clzss_pkg::FLAG_IDX_DONE;
                  phase    <= clzss_pkg::PH_FLAG;
                end else begin
                  flag_idx <= idx_next;
                end
              end
            end
            clzss_pkg::PH_HIGH: begin
              acc       <= ref_off;
              remaining <= run_len;
              if (idx_next >= clzss_pkg::FLAG_IDX_DONE) begin
                flag_idx <= clzss_pkg::FLAG_IDX_DONE;
                phase    <= clzss_pkg::PH_FLAG;
              end else begin
                flag_idx <= idx_next;
                phase    <= clzss_pkg::PH_ITEM;
              end
              if (run_len != '0) begin
                state <= S_OFFRED;
              end
            end
            default: begin
              flags    <= invert_flags ? ~byte_q : byte_q;
              flag_idx <= '0;
              phase    <= clzss_pkg::PH_ITEM;
            end
          endcase
        end
        S_OFFRED: begin
          if (sub_ge) begin
            acc <= sub_out;
          end else begin
            caddr <= acc[AW-1:0];
            state <= S_CP;
          end
        end
        S_CP: begin
          if (can_emit) begin
            out_valid   <= 1'b1;
            out_byte    <= cp_data;
            last_of_run <= (remaining == 5'd1);
            wp          <= wp_inc;
            count       <= count_inc;
            caddr       <= caddr_inc;
            remaining   <= remaining - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (finish) begin
        state <= S_IDLE;
        if (eos_q) begin
          phase       <= clzss_pkg::PH_FLAG;
          flags       <= '0;
          flag_idx    <= clzss_pkg::FLAG_IDX_DONE;
          saved_low   <= '0;
          stream_open <= 1'b0;
        end
      end
    end
  end

endmodule

/* sv/clzss_checker.sv */
// ----------------------------------------------------------------------------
// clzss_checker
// Port-level checks for the configurable lzss decoder.
// ----------------------------------------------------------------------------
module clzss_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("stalled output item changed");

  // nothing is shown right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // in_ready falls once an item is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted item");

  // while a copy is still running no new item is taken
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> !in_ready)
    else $error("ready in the middle of a copy");

endmodule

bind configurable_lzss_decoder clzss_checker u_clzss_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .last_of_run (last_of_run)
);
